// ===== hw/rtl/i2crtq_pkg.sv =====
`default_nettype none

package i2crtq_pkg;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] length;
        logic [7:0] reg_addr;
        logic [6:0] dev_addr;
        logic       rw_dir;
    } ticket_t;

    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_TX_READY  = 3'd1;
    localparam logic [2:0] OP_XFER_DONE = 3'd2;
    localparam logic [2:0] OP_NACK      = 3'd3;
    localparam logic [2:0] OP_BUS_ERR   = 3'd4;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CMD    = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [2:0] CMD_START_WR   = 3'd0;
    localparam logic [2:0] CMD_SEND_BYTE  = 3'd1;
    localparam logic [2:0] CMD_BURST_WR   = 3'd2;
    localparam logic [2:0] CMD_READ_BURST = 3'd3;
    localparam logic [2:0] CMD_STOP       = 3'd4;
    localparam logic [2:0] CMD_RESET      = 3'd5;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_ERROR    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ACCEPTED = 2'd3;

    typedef enum logic [3:0] {
        RES_ZERO_DONE,
        RES_FULL,
        RES_ACCEPT,
        RES_START_NEW,
        RES_SEND_REG,
        RES_BURST_WR,
        RES_READ_BURST,
        RES_STOP,
        RES_DONE,
        RES_ENGINE_RESET,
        RES_ERROR,
        RES_START_NEXT
    } res_t;

    typedef struct packed {
        logic load;
        logic emit;
        res_t res;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       len_zero;
        logic       full;
        logic       busy;
        logic       cur_rw;
        logic       reg_sent;
        logic       remain;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_register_transfer_queue_core.sv =====
`default_nettype none

// Queue of I2C register-transfer tickets that sequences a bus engine. Each input transaction is
// either a new ticket (tuser 0) or an engine event (transmit ready, transfer complete, NACK,
// bus error); it yields zero to three output transactions, each an add report, an engine command
// or a completion report, with tlast on the final one. An input transaction is first registered,
// then its output transactions are made one at a time, each once the output register is free;
// an input that yields none still passes through the first output state. Before the start command
// of the next queued ticket a gap state lets the ticket store be read at the new head. The
// next input is taken as soon as the last output transaction of the previous one sits in the
// output register. Up to QUEUE_DEPTH tickets are held; a ticket of zero length completes at once
// and an add to a full queue is refused.

module i2c_register_transfer_queue_core
    import i2crtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // rw_dir, dev_addr, reg_addr, length, tag, now_time
    input  wire logic [63:0] s_axis_tdata,
    // op
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cmd, bus_addr, count, out_byte, out_tag, status, stamp, zero padding
    output logic [71:0]      m_axis_tdata,
    // kind
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    i2crtq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    i2crtq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/i2crtq_ctrl.sv =====
`default_nettype none

module i2crtq_ctrl
    import i2crtq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire dp_status_t stat,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FIRST  = 5'b00010,
        S_SECOND = 5'b00100,
        S_GAP    = 5'b01000,
        S_THIRD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic want;
    res_t res;
    logic last;
    logic is_event;

    assign is_event = (stat.op == OP_TX_READY) || (stat.op == OP_XFER_DONE)
                      || (stat.op == OP_NACK) || (stat.op == OP_BUS_ERR);

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        want          = 1'b0;
        res           = RES_ZERO_DONE;
        last          = 1'b0;
        cmd.load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (stat.op == OP_ADD)
                begin
                    want = 1'b1;
                    if (stat.len_zero)
                    begin
                        res  = RES_ZERO_DONE;
                        last = 1'b1;
                    end
                    else if (stat.full)
                    begin
                        res  = RES_FULL;
                        last = 1'b1;
                    end
                    else
                    begin
                        res  = RES_ACCEPT;
                        last = stat.busy;
                    end
                end
                else if (is_event && stat.busy)
                begin
                    want = 1'b1;
                    if (stat.op == OP_TX_READY)
                    begin
                        res  = RES_SEND_REG;
                        last = stat.cur_rw;
                    end
                    else if (stat.op == OP_XFER_DONE)
                    begin
                        res  = stat.reg_sent ? RES_READ_BURST : RES_STOP;
                        last = stat.reg_sent;
                    end
                    else
                    begin
                        res = RES_ENGINE_RESET;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
                if (want && stat.out_free)
                begin
                    state_next = last ? S_IDLE : S_SECOND;
                end
            end
            S_SECOND:
            begin
                want = 1'b1;
                if (stat.op == OP_ADD)
                begin
                    res  = RES_START_NEW;
                    last = 1'b1;
                end
                else if (stat.op == OP_TX_READY)
                begin
                    res  = RES_BURST_WR;
                    last = 1'b1;
                end
                else
                begin
                    res  = (stat.op == OP_XFER_DONE) ? RES_DONE : RES_ERROR;
                    last = !stat.remain;
                end
                if (stat.out_free)
                begin
                    state_next = last ? S_IDLE : S_GAP;
                end
            end
            S_GAP:
            begin
                // The store read of the new head ticket lands during this cycle.
                state_next = S_THIRD;
            end
            S_THIRD:
            begin
                want = 1'b1;
                res  = RES_START_NEXT;
                last = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.emit = want && stat.out_free;
        cmd.res  = res;
        cmd.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2crtq_dp.sv =====
`default_nettype none

module i2crtq_dp
    import i2crtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       stat,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [1:0] PH_ADDR = 2'd0;
    localparam logic [1:0] PH_REG  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    ticket_t mem [QUEUE_DEPTH];
    ticket_t rd_reg;
    ticket_t in_tkt_reg;
    logic [2:0]  op_reg;
    logic [31:0] now_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    logic             busy_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;

    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic [2:0]       out_cmd_reg;
    logic [6:0]       out_addr_reg;
    logic [8:0]       out_count_reg;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_tag_reg;
    logic [1:0]       out_status_reg;
    logic [31:0]      out_stamp_reg;
    logic             out_last_reg;

    logic [1:0]       r_kind;
    logic [2:0]       r_cmd;
    logic [6:0]       r_addr;
    logic [8:0]       r_count;
    logic [7:0]       r_byte;
    logic [7:0]       r_tag;
    logic [1:0]       r_status;
    logic [31:0]      r_stamp;

    logic [SUM_W-1:0] slot_sum;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] head_inc;

    assign slot_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign slot     = !busy_reg ? '0
                    : (slot_sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(slot_sum - SUM_W'(QUEUE_DEPTH))
                    : IDX_W'(slot_sum);
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign stat.op       = op_reg;
    assign stat.len_zero = (in_tkt_reg.length == 8'd0);
    assign stat.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.busy     = busy_reg;
    assign stat.cur_rw   = rd_reg.rw_dir;
    assign stat.reg_sent = (phase_reg == PH_REG);
    assign stat.remain   = (count_reg > CNT_W'(1));
    assign stat.out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        r_kind     = KIND_ADD;
        r_cmd      = CMD_START_WR;
        r_addr     = '0;
        r_count    = '0;
        r_byte     = '0;
        r_tag      = '0;
        r_status   = ST_DONE;
        r_stamp    = '0;
        head_next  = head_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        unique case (cmd.res)
            RES_ZERO_DONE:
            begin
                r_kind  = KIND_REPORT;
                r_tag   = in_tkt_reg.tag;
                r_stamp = now_reg;
            end
            RES_FULL:
            begin
                r_tag    = in_tkt_reg.tag;
                r_status = ST_FULL;
            end
            RES_ACCEPT:
            begin
                r_tag      = in_tkt_reg.tag;
                r_status   = ST_ACCEPTED;
                count_next = count_reg + 1'b1;
                if (!busy_reg)
                begin
                    head_next = '0;
                    busy_next = 1'b1;
                end
            end
            RES_START_NEW:
            begin
                r_kind     = KIND_CMD;
                r_addr     = in_tkt_reg.dev_addr;
                r_count    = in_tkt_reg.rw_dir ? 9'd1 : 9'd1 + {1'b0, in_tkt_reg.length};
                phase_next = PH_ADDR;
            end
            RES_SEND_REG:
            begin
                r_kind     = KIND_CMD;
                r_cmd      = CMD_SEND_BYTE;
                r_byte     = rd_reg.reg_addr;
                phase_next = rd_reg.rw_dir ? PH_REG : PH_DATA;
            end
            RES_BURST_WR:
            begin
                r_kind  = KIND_CMD;
                r_cmd   = CMD_BURST_WR;
                r_count = {1'b0, rd_reg.length};
            end
            RES_READ_BURST:
            begin
                r_kind     = KIND_CMD;
                r_cmd      = CMD_READ_BURST;
                r_addr     = rd_reg.dev_addr;
                r_count    = {1'b0, rd_reg.length};
                phase_next = PH_DATA;
            end
            RES_STOP:
            begin
                r_kind     = KIND_CMD;
                r_cmd      = CMD_STOP;
                phase_next = PH_DONE;
            end
            RES_DONE:
            begin
                r_kind     = KIND_REPORT;
                r_tag      = rd_reg.tag;
                r_stamp    = now_reg;
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    head_next = head_inc;
                end
            end
            RES_ENGINE_RESET:
            begin
                r_kind     = KIND_CMD;
                r_cmd      = CMD_RESET;
                phase_next = PH_DONE;
            end
            RES_ERROR:
            begin
                r_kind     = KIND_REPORT;
                r_tag      = rd_reg.tag;
                r_status   = ST_ERROR;
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    head_next = head_inc;
                end
            end
            RES_START_NEXT:
            begin
                r_kind     = KIND_CMD;
                r_addr     = rd_reg.dev_addr;
                r_count    = rd_reg.rw_dir ? 9'd1 : 9'd1 + {1'b0, rd_reg.length};
                phase_next = PH_ADDR;
            end
            default:
            begin
                r_kind = KIND_ADD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            phase_reg     <= PH_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                busy_reg      <= busy_next;
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_tkt_reg <= ticket_t'(s_axis_tdata[31:0]);
            now_reg    <= s_axis_tdata[63:32];
            op_reg     <= s_axis_tuser;
        end
        if (cmd.emit)
        begin
            out_kind_reg   <= r_kind;
            out_cmd_reg    <= r_cmd;
            out_addr_reg   <= r_addr;
            out_count_reg  <= r_count;
            out_byte_reg   <= r_byte;
            out_tag_reg    <= r_tag;
            out_status_reg <= r_status;
            out_stamp_reg  <= r_stamp;
            out_last_reg   <= cmd.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && (cmd.res == RES_ACCEPT))
        begin
            mem[slot] <= in_tkt_reg;
        end
        rd_reg <= mem[head_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_stamp_reg, out_status_reg, out_tag_reg, out_byte_reg,
                            out_count_reg, out_addr_reg, out_cmd_reg};

endmodule

`default_nettype wire

// ===== bench/i2c_register_transfer_queue_core_test.sv =====
`timescale 1ns / 1ps

module i2c_register_transfer_queue_core_test
    import i2crtq_pkg::*;
();

    localparam int QUEUE_DEPTH = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    typedef enum logic [1:0] {PH_ADDR, PH_REG, PH_DATA, PH_DONE} xfer_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  cmd;
        logic [6:0]  bus_addr;
        logic [8:0]  count;
        logic [7:0]  out_byte;
        logic [7:0]  out_tag;
        logic [1:0]  status;
        logic [31:0] stamp;
        logic        last;
    } bus_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    ticket_t     model_ticket [QUEUE_DEPTH];
    int          model_head;
    int          model_count;
    logic        model_busy;
    xfer_phase_t model_phase;

    bus_result_t expected_results [$];
    int          predicted_total = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;

    i2c_register_transfer_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bus_result_t engine_cmd(input logic [2:0] cmd, input logic [6:0] addr,
                                               input logic [8:0] cnt, input logic [7:0] data);
        bus_result_t r;
        r = '0;
        r.kind = KIND_CMD;
        r.cmd = cmd;
        r.bus_addr = addr;
        r.count = cnt;
        r.out_byte = data;
        return r;
    endfunction

    function automatic bus_result_t ticket_report(input logic [1:0] kind, input logic [7:0] tag,
                                                  input logic [1:0] status,
                                                  input logic [31:0] stamp);
        bus_result_t r;
        r = '0;
        r.kind = kind;
        r.out_tag = tag;
        r.status = status;
        r.stamp = stamp;
        return r;
    endfunction

    function automatic void start_current(ref bus_result_t step_out [$]);
        ticket_t cur;
        logic [8:0] cnt;
        cur = model_ticket[model_head];
        cnt = cur.rw_dir ? 9'd1 : 9'd1 + {1'b0, cur.length};
        model_phase = PH_ADDR;
        step_out.push_back(engine_cmd(CMD_START_WR, cur.dev_addr, cnt, '0));
    endfunction

    function automatic void finish_current(ref bus_result_t step_out [$],
                                           input logic [1:0] status, input logic [31:0] stamp);
        step_out.push_back(ticket_report(KIND_REPORT, model_ticket[model_head].tag,
                                         status, stamp));
        if (model_count > 0)
            model_count--;
        if (model_count == 0)
            model_busy = 1'b0;
        else
        begin
            model_head = (model_head + 1) % QUEUE_DEPTH;
            start_current(step_out);
        end
    endfunction

    function automatic void queue_model_step(input logic [2:0] op, input ticket_t tk,
                                             input logic [31:0] now);
        bus_result_t step_out [$];
        ticket_t cur;
        int slot;
        if (op == OP_ADD)
        begin
            if (tk.length == 0)
                step_out.push_back(ticket_report(KIND_REPORT, tk.tag, ST_DONE, now));
            else if (model_count >= QUEUE_DEPTH)
                step_out.push_back(ticket_report(KIND_ADD, tk.tag, ST_FULL, '0));
            else
            begin
                if (!model_busy)
                    model_head = 0;
                slot = (model_head + model_count) % QUEUE_DEPTH;
                model_ticket[slot] = tk;
                model_count++;
                step_out.push_back(ticket_report(KIND_ADD, tk.tag, ST_ACCEPTED, '0));
                if (!model_busy)
                begin
                    model_busy = 1'b1;
                    model_head = slot;
                    start_current(step_out);
                end
            end
        end
        else if (op <= OP_BUS_ERR && model_busy)
        begin
            cur = model_ticket[model_head];
            if (op == OP_TX_READY)
            begin
                step_out.push_back(engine_cmd(CMD_SEND_BYTE, '0, '0, cur.reg_addr));
                if (!cur.rw_dir)
                begin
                    step_out.push_back(engine_cmd(CMD_BURST_WR, '0, {1'b0, cur.length}, '0));
                    model_phase = PH_DATA;
                end
                else
                    model_phase = PH_REG;
            end
            else if (op == OP_XFER_DONE)
            begin
                if (model_phase == PH_REG)
                begin
                    step_out.push_back(engine_cmd(CMD_READ_BURST, cur.dev_addr,
                                                  {1'b0, cur.length}, '0));
                    model_phase = PH_DATA;
                end
                else
                begin
                    step_out.push_back(engine_cmd(CMD_STOP, '0, '0, '0));
                    model_phase = PH_DONE;
                    finish_current(step_out, ST_DONE, now);
                end
            end
            else
            begin
                step_out.push_back(engine_cmd(CMD_RESET, '0, '0, '0));
                model_phase = PH_DONE;
                finish_current(step_out, ST_ERROR, '0);
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            expected_results.push_back(step_out[i]);
        predicted_total += step_out.size();
    endfunction

    function automatic ticket_t random_ticket();
        ticket_t tk;
        int r;
        tk.rw_dir = 1'($urandom_range(0, 1));
        tk.dev_addr = 7'($urandom_range(0, 127));
        tk.reg_addr = 8'($urandom_range(0, 255));
        tk.tag = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 8)
            tk.length = 8'd0;
        else if (r < 18)
            tk.length = 8'd255;
        else
            tk.length = 8'($urandom_range(1, 255));
        return tk;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic [2:0] op, input ticket_t tk, input logic [31:0] now);
        if (!calm && $urandom_range(0, 99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {now, tk};
        do @(posedge clk); while (!s_axis_tready);
        queue_model_step(op, tk, now);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic test_idle_events();
        for (int op = OP_TX_READY; op <= OP_LAST_CODE; op++)
            send_item(3'(op), random_ticket(), $urandom());
        wait_drained();
    endtask

    task automatic test_zero_length();
        ticket_t tk;
        tk = '1;
        tk.length = 8'd0;
        send_item(OP_ADD, tk, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_write_transfer();
        ticket_t tk;
        tk = '1;
        tk.rw_dir = 1'b0;
        tk.tag = 8'd0;
        send_item(OP_ADD, tk, 32'd0);
        send_item(OP_TX_READY, random_ticket(), $urandom());
        send_item(OP_XFER_DONE, random_ticket(), 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_read_transfer();
        ticket_t tk;
        tk = '0;
        tk.rw_dir = 1'b1;
        tk.length = 8'd1;
        tk.tag = 8'hFF;
        send_item(OP_ADD, tk, $urandom());
        send_item(OP_TX_READY, random_ticket(), $urandom());
        send_item(OP_XFER_DONE, random_ticket(), $urandom());
        send_item(OP_XFER_DONE, random_ticket(), 32'd0);
        wait_drained();
    endtask

    task automatic test_full_queue();
        ticket_t tk;
        for (int i = 0; i <= QUEUE_DEPTH; i++)
        begin
            tk = random_ticket();
            if (tk.length == 0)
                tk.length = 8'd1;
            send_item(OP_ADD, tk, $urandom());
        end
        send_item(OP_NACK, random_ticket(), $urandom());
        send_item(OP_BUS_ERR, random_ticket(), $urandom());
        send_item(OP_XFER_DONE, random_ticket(), $urandom());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int active_items;
        int prior_total;
        int r;
        int add_pct;
        logic [2:0] op;
        active_items = 0;
        while (active_items < RANDOM_ITEMS)
        begin
            calm = (active_items >= 150 && active_items < 250);
            add_pct = ((active_items / 50) % 2) ? 45 : 12;
            r = $urandom_range(0, 99);
            if (r < add_pct || !model_busy && r < 93)
                op = OP_ADD;
            else if (r < 93)
                op = (model_phase == PH_ADDR) ? OP_TX_READY : OP_XFER_DONE;
            else
                op = 3'($urandom_range(OP_TX_READY, OP_LAST_CODE));
            prior_total = predicted_total;
            send_item(op, random_ticket(), $urandom());
            if (predicted_total != prior_total)
                active_items++;
        end
        calm = 1'b0;
        wait_drained();
    endtask

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);

    always @(posedge clk)
    begin
        bus_result_t got;
        bus_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.cmd = m_axis_tdata[2:0];
            got.bus_addr = m_axis_tdata[9:3];
            got.count = m_axis_tdata[18:10];
            got.out_byte = m_axis_tdata[26:19];
            got.out_tag = m_axis_tdata[34:27];
            got.status = m_axis_tdata[36:35];
            got.stamp = m_axis_tdata[68:37];
            got.last = m_axis_tlast;
            if (expected_results.size() == 0)
                report_mismatch("unexpected transaction", m_axis_tdata[31:0], '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.cmd !== want.cmd)
                    report_mismatch("cmd", 32'(got.cmd), 32'(want.cmd));
                if (got.bus_addr !== want.bus_addr)
                    report_mismatch("bus_addr", 32'(got.bus_addr), 32'(want.bus_addr));
                if (got.count !== want.count)
                    report_mismatch("count", 32'(got.count), 32'(want.count));
                if (got.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
                if (got.out_tag !== want.out_tag)
                    report_mismatch("out_tag", 32'(got.out_tag), 32'(want.out_tag));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.stamp !== want.stamp)
                    report_mismatch("stamp", got.stamp, want.stamp);
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
                if (m_axis_tdata[71:69] !== 3'b000)
                    report_mismatch("padding", 32'(m_axis_tdata[71:69]), '0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        model_head = 0;
        model_count = 0;
        model_busy = 1'b0;
        model_phase = PH_DONE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_events();
        test_zero_length();
        test_write_transfer();
        test_read_transfer();
        test_full_queue();
        test_random_traffic();
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
